[src/fzpid_pkg.sv]
// shared constants, types and rule tables for the fuzzy pid gain scheduler
// no dependencies; used by every module of the block
`default_nettype none

package fzpid_pkg;

    // quotient bits of the quantizer divide; |q| is at most 7.0 in q.16
    localparam int unsigned QBITS = 19;
    localparam int unsigned NUM_W = 35;
    localparam int unsigned DEN_W = 17;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;

    localparam logic [1:0] REG_LOWER = 2'd0;
    localparam logic [1:0] REG_UPPER = 2'd1;
    localparam logic [1:0] REG_KP    = 2'd2;
    localparam logic [1:0] REG_KI    = 2'd3;

    localparam logic [14:0] LOWER_RST = 15'd7680;
    localparam logic [14:0] UPPER_RST = 15'd7680;
    localparam logic [15:0] KP_RST    = 16'd18350;
    localparam logic [15:0] KI_RST    = 16'd6554;

    localparam logic [13:0] SLOPE_Q16 = 14'd9372;
    localparam logic signed [17:0] ONE_Q16 = 18'sd65536;
    localparam logic [19:0] ONE_MAG   = 20'd65536;
    localparam logic [19:0] THREE_MAG = 20'd196608;

    typedef logic signed [3:0] rule_t;

    localparam rule_t KP_RULES [7][7] = '{
        '{ 4'sd7,  4'sd3,  4'sd1,  4'sd1,  4'sd0,  4'sd0,  4'sd0},
        '{ 4'sd1,  4'sd1,  4'sd1,  4'sd0,  4'sd0,  4'sd0, -4'sd1},
        '{-4'sd1, -4'sd3, -4'sd3, -4'sd7, -4'sd3, -4'sd3, -4'sd3},
        '{-4'sd3, -4'sd3, -4'sd7, -4'sd7, -4'sd7, -4'sd3, -4'sd3},
        '{-4'sd3, -4'sd3, -4'sd3, -4'sd7, -4'sd3, -4'sd3, -4'sd1},
        '{-4'sd1,  4'sd0,  4'sd0,  4'sd0,  4'sd1,  4'sd1,  4'sd1},
        '{ 4'sd0,  4'sd0,  4'sd0,  4'sd1,  4'sd1,  4'sd3,  4'sd7}
    };

    localparam rule_t KI_RULES [7][7] = '{
        '{-4'sd7, -4'sd7, -4'sd7, -4'sd3, -4'sd3, -4'sd1, -4'sd1},
        '{-4'sd7, -4'sd1,  4'sd0,  4'sd0,  4'sd0,  4'sd1,  4'sd7},
        '{-4'sd3, -4'sd1, -4'sd1,  4'sd0,  4'sd1,  4'sd1,  4'sd7},
        '{ 4'sd1,  4'sd3,  4'sd7,  4'sd7,  4'sd7,  4'sd3,  4'sd1},
        '{ 4'sd7,  4'sd1,  4'sd1,  4'sd0, -4'sd1, -4'sd1, -4'sd3},
        '{ 4'sd7,  4'sd1,  4'sd0,  4'sd0,  4'sd0, -4'sd1, -4'sd7},
        '{-4'sd1, -4'sd1, -4'sd3, -4'sd3, -4'sd7, -4'sd7, -4'sd7}
    };

    // quantized value as sign and magnitude, q.16
    typedef struct packed {
        logic        neg;
        logic [19:0] mag;
    } qval_t;

    typedef struct packed {
        logic [2:0]         idx;
        logic signed [17:0] m0;
        logic signed [17:0] m1;
    } memb_t;

    typedef struct packed {
        logic [14:0] lower_limit;
        logic [14:0] upper_limit;
        logic [15:0] kp_scale;
        logic [15:0] ki_scale;
    } cfg_t;

endpackage

`default_nettype wire

[src/fzpid_regs.sv]
// apb register file: limits and gain scales
// depends on fzpid_pkg
`default_nettype none

module fzpid_regs (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [3:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic      [31:0]      prdata,
    output fzpid_pkg::cfg_t       cfg
);

    fzpid_pkg::cfg_t cfg_reg;
    logic            wr;

    assign wr  = psel && penable && pwrite;
    assign cfg = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lower_limit <= fzpid_pkg::LOWER_RST;
            cfg_reg.upper_limit <= fzpid_pkg::UPPER_RST;
            cfg_reg.kp_scale    <= fzpid_pkg::KP_RST;
            cfg_reg.ki_scale    <= fzpid_pkg::KI_RST;
        end else if (wr) begin
            case (paddr[3:2])
                fzpid_pkg::REG_LOWER: cfg_reg.lower_limit <= pwdata[14:0];
                fzpid_pkg::REG_UPPER: cfg_reg.upper_limit <= pwdata[14:0];
                fzpid_pkg::REG_KP:    cfg_reg.kp_scale    <= pwdata[15:0];
                fzpid_pkg::REG_KI:    cfg_reg.ki_scale    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            fzpid_pkg::REG_LOWER: prdata = {17'd0, cfg_reg.lower_limit};
            fzpid_pkg::REG_UPPER: prdata = {17'd0, cfg_reg.upper_limit};
            fzpid_pkg::REG_KP:    prdata = {16'd0, cfg_reg.kp_scale};
            fzpid_pkg::REG_KI:    prdata = {16'd0, cfg_reg.ki_scale};
            default:              prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

[src/fzpid_quant.sv]
// error forming, range check and the pipelined restoring divide that quantizes
// error and error change; depends on fzpid_pkg
`default_nettype none

module fzpid_quant (
    input  wire logic               aclk,
    input  wire logic               en,
    input  wire logic signed [15:0] set_point,
    input  wire logic signed [15:0] measured,
    input  wire logic signed [15:0] previous_measured,
    input  wire fzpid_pkg::cfg_t    cfg,
    output fzpid_pkg::qval_t        qe,
    output fzpid_pkg::qval_t        qc,
    output logic [1:0]              status
);

    localparam int unsigned QB = fzpid_pkg::QBITS;
    localparam int unsigned NW = fzpid_pkg::NUM_W;
    localparam int unsigned DW = fzpid_pkg::DEN_W;

    // stage a
    logic signed [16:0] err_reg, derr_reg;
    // division stages; index 0 is loaded by stage b
    logic [NW-1:0] rem_e_reg [QB+1];
    logic [NW-1:0] rem_c_reg [QB+1];
    logic [QB-1:0] quo_e_reg [QB+1];
    logic [QB-1:0] quo_c_reg [QB+1];
    logic          neg_e_reg [QB+1];
    logic          neg_c_reg [QB+1];
    logic [1:0]    st_reg    [QB+1];
    // fixup stage
    fzpid_pkg::qval_t qe_reg, qc_reg;
    logic [1:0]       st_out_reg;

    logic [15:0]        lim_sum;
    logic [DW-1:0]      den_e, den_c;
    logic signed [18:0] err_x, derr_x, s_x, s2_x;
    logic [16:0]        abs_e, abs_c;
    logic [19:0]        m7_e, m7_c;
    logic [1:0]         st_next;

    assign lim_sum = {1'b0, cfg.lower_limit} + {1'b0, cfg.upper_limit};
    assign den_e   = {1'b0, lim_sum};
    assign den_c   = {lim_sum, 1'b0};

    always_ff @(posedge aclk) begin
        if (en) begin
            err_reg  <= {set_point[15], set_point} - {measured[15], measured};
            derr_reg <= {previous_measured[15], previous_measured} - {measured[15], measured};
        end
    end

    // stage b: range check against the limit sum (twice it for error change) and numerators 7*|x|*2^16
    assign err_x  = {{2{err_reg[16]}}, err_reg};
    assign derr_x = {{2{derr_reg[16]}}, derr_reg};
    assign s_x    = {3'b000, lim_sum};
    assign s2_x   = {2'b00, lim_sum, 1'b0};
    assign abs_e  = err_reg[16]  ? 17'(-err_reg)  : 17'(err_reg);
    assign abs_c  = derr_reg[16] ? 17'(-derr_reg) : 17'(derr_reg);
    assign m7_e   = {abs_e, 3'b000} - {3'b000, abs_e};
    assign m7_c   = {abs_c, 3'b000} - {3'b000, abs_c};

    always_comb begin
        if (lim_sum == 16'd0) begin
            st_next = fzpid_pkg::ST_ZERO;
        end else if (err_x < -s_x || err_x >= s_x || derr_x < -s2_x || derr_x >= s2_x) begin
            st_next = fzpid_pkg::ST_RANGE;
        end else begin
            st_next = fzpid_pkg::ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_e_reg[0] <= {m7_e[18:0], 16'd0};
            rem_c_reg[0] <= {m7_c[18:0], 16'd0};
            quo_e_reg[0] <= '0;
            quo_c_reg[0] <= '0;
            neg_e_reg[0] <= err_reg[16];
            neg_c_reg[0] <= derr_reg[16];
            st_reg[0]    <= st_next;
        end
    end

    // one quotient bit per stage, msb first
    for (genvar j = 1; j <= QB; j++) begin : g_div
        localparam int unsigned B = QB - j;
        logic [NW:0] sh_e, sh_c, dif_e, dif_c;
        logic        ge_e, ge_c;

        assign sh_e  = {{(NW + 1 - DW){1'b0}}, den_e} << B;
        assign sh_c  = {{(NW + 1 - DW){1'b0}}, den_c} << B;
        assign ge_e  = {1'b0, rem_e_reg[j-1]} >= sh_e;
        assign ge_c  = {1'b0, rem_c_reg[j-1]} >= sh_c;
        assign dif_e = {1'b0, rem_e_reg[j-1]} - sh_e;
        assign dif_c = {1'b0, rem_c_reg[j-1]} - sh_c;

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_e_reg[j] <= ge_e ? dif_e[NW-1:0] : rem_e_reg[j-1];
                rem_c_reg[j] <= ge_c ? dif_c[NW-1:0] : rem_c_reg[j-1];
                quo_e_reg[j] <= quo_e_reg[j-1] | (QB'(ge_e) << B);
                quo_c_reg[j] <= quo_c_reg[j-1] | (QB'(ge_c) << B);
                neg_e_reg[j] <= neg_e_reg[j-1];
                neg_c_reg[j] <= neg_c_reg[j-1];
                st_reg[j]    <= st_reg[j-1];
            end
        end
    end

    // floor of a negative quotient rounds the magnitude up
    always_ff @(posedge aclk) begin
        if (en) begin
            qe_reg.neg <= neg_e_reg[QB];
            qc_reg.neg <= neg_c_reg[QB];
            qe_reg.mag <= {1'b0, quo_e_reg[QB]}
                          + 20'(neg_e_reg[QB] && (rem_e_reg[QB] != '0));
            qc_reg.mag <= {1'b0, quo_c_reg[QB]}
                          + 20'(neg_c_reg[QB] && (rem_c_reg[QB] != '0));
            st_out_reg <= st_reg[QB];
        end
    end

    assign qe     = qe_reg;
    assign qc     = qc_reg;
    assign status = st_out_reg;

endmodule

`default_nettype wire

[src/fzpid_blend.sv]
// membership weights, 2x2 rule blend, scaling with rounding and saturation
// depends on fzpid_pkg
`default_nettype none

module fzpid_blend (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire fzpid_pkg::qval_t qe,
    input  wire fzpid_pkg::qval_t qc,
    input  wire logic [1:0]       status_in,
    input  wire fzpid_pkg::cfg_t  cfg,
    output logic signed [15:0]    kp_adjust,
    output logic signed [15:0]    ki_adjust,
    output logic [1:0]            status
);

    function automatic fzpid_pkg::memb_t membership(input fzpid_pkg::qval_t q);
        fzpid_pkg::memb_t r;
        logic [33:0]      prod;
        logic signed [17:0] a;
        prod = q.mag * fzpid_pkg::SLOPE_Q16;
        a    = $signed({1'b0, prod[32:16]});
        if (q.neg && q.mag > fzpid_pkg::THREE_MAG) begin
            r.idx = 3'd0;
        end else if (q.neg && q.mag > fzpid_pkg::ONE_MAG) begin
            r.idx = 3'd1;
        end else if (q.neg && q.mag != 20'd0) begin
            r.idx = 3'd2;
        end else if (q.mag < fzpid_pkg::ONE_MAG) begin
            r.idx = 3'd3;
        end else if (q.mag < fzpid_pkg::THREE_MAG) begin
            r.idx = 3'd4;
        end else begin
            r.idx = 3'd5;
        end
        r.m1 = a;
        r.m0 = fzpid_pkg::ONE_Q16 - a;
        return r;
    endfunction

    // round to q2.14 (add 2^33, floor by 2^34) and clamp
    function automatic logic signed [15:0] round_sat(input logic signed [42:0] ph,
                                                     input logic [31:0] pl);
        logic signed [59:0] t;
        logic signed [25:0] v;
        t = $signed({ph[42], ph, 16'd0}) + $signed({28'd0, pl}) + 60'sh2_0000_0000;
        v = t[59:34];
        if (v > 26'sd32767) begin
            return 16'sh7fff;
        end else if (v < -26'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    fzpid_pkg::memb_t  me_reg, mc_reg;
    logic [1:0]        st_m_reg, st_r_reg, st_p_reg, st_s_reg, st_x_reg;
    logic signed [17:0] e0_r_reg, e1_r_reg;
    logic signed [22:0] kr0_reg, kr1_reg, ir0_reg, ir1_reg;
    logic signed [40:0] kp0_reg, kp1_reg, ip0_reg, ip1_reg;
    logic signed [41:0] ksum_reg, isum_reg;
    logic signed [42:0] kph_reg, iph_reg;
    logic [31:0]        kpl_reg, ipl_reg;

    logic [2:0] ie0, ie1, ic0, ic1;

    assign ie0 = me_reg.idx;
    assign ie1 = me_reg.idx + 3'd1;
    assign ic0 = mc_reg.idx;
    assign ic1 = mc_reg.idx + 3'd1;

    always_ff @(posedge aclk) begin
        if (en) begin
            // weights
            me_reg   <= membership(qe);
            mc_reg   <= membership(qc);
            st_m_reg <= status_in;
            // rows of the blend along the error change axis
            kr0_reg  <= 23'(mc_reg.m0 * fzpid_pkg::KP_RULES[ie0][ic0])
                        + 23'(mc_reg.m1 * fzpid_pkg::KP_RULES[ie0][ic1]);
            kr1_reg  <= 23'(mc_reg.m0 * fzpid_pkg::KP_RULES[ie1][ic0])
                        + 23'(mc_reg.m1 * fzpid_pkg::KP_RULES[ie1][ic1]);
            ir0_reg  <= 23'(mc_reg.m0 * fzpid_pkg::KI_RULES[ie0][ic0])
                        + 23'(mc_reg.m1 * fzpid_pkg::KI_RULES[ie0][ic1]);
            ir1_reg  <= 23'(mc_reg.m0 * fzpid_pkg::KI_RULES[ie1][ic0])
                        + 23'(mc_reg.m1 * fzpid_pkg::KI_RULES[ie1][ic1]);
            e0_r_reg <= me_reg.m0;
            e1_r_reg <= me_reg.m1;
            st_r_reg <= st_m_reg;
            // error axis weights
            kp0_reg  <= e0_r_reg * kr0_reg;
            kp1_reg  <= e1_r_reg * kr1_reg;
            ip0_reg  <= e0_r_reg * ir0_reg;
            ip1_reg  <= e1_r_reg * ir1_reg;
            st_p_reg <= st_r_reg;
            ksum_reg <= 42'(kp0_reg) + 42'(kp1_reg);
            isum_reg <= 42'(ip0_reg) + 42'(ip1_reg);
            st_s_reg <= st_p_reg;
            // scale split in high and low partial products
            kph_reg  <= $signed(ksum_reg[41:16]) * $signed({1'b0, cfg.kp_scale});
            iph_reg  <= $signed(isum_reg[41:16]) * $signed({1'b0, cfg.ki_scale});
            kpl_reg  <= ksum_reg[15:0] * cfg.kp_scale;
            ipl_reg  <= isum_reg[15:0] * cfg.ki_scale;
            st_x_reg <= st_s_reg;
        end
    end

    assign status    = st_x_reg;
    assign kp_adjust = (st_x_reg == fzpid_pkg::ST_OK) ? round_sat(kph_reg, kpl_reg) : 16'sd0;
    assign ki_adjust = (st_x_reg == fzpid_pkg::ST_OK) ? round_sat(iph_reg, ipl_reg) : 16'sd0;

endmodule

`default_nettype wire

[src/fuzzy_pid_gain_adjust_core.sv]
// top level of the fuzzy pid gain scheduler: apb registers, pipeline, output skid
// depends on fzpid_pkg, fzpid_regs, fzpid_quant, fzpid_blend
`default_nettype none

// Fuzzy gain scheduler for an angle PID loop. Each input word (set point,
// measurement, previous measurement, Q8.8) yields one result word with the Kp and
// Ki adjustments in Q2.14 and a status code. The block takes one word per clock
// while s_ready is high; a 19-stage one-bit-per-stage divider quantizes error and
// error change by the limit sum. The whole pipeline advances together; an output
// register and a one-word skid buffer let it keep accepting words while one result
// waits. Registers are written over APB at byte addresses 0, 4, 8 and 12; the
// user must do so only while no word is in flight, which the block does not check.
module fuzzy_pid_gain_adjust_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [15:0] s_set_point,
    input  wire logic signed [15:0] s_measured,
    input  wire logic signed [15:0] s_previous_measured,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_kp_adjust,
    output logic signed [15:0]      m_ki_adjust,
    output logic [1:0]              m_status
);

    // a, b, divide stages, fixup, then five blend stages
    localparam int unsigned NSTAGE = fzpid_pkg::QBITS + 8;

    fzpid_pkg::cfg_t  cfg;
    fzpid_pkg::qval_t qe, qc;
    logic [1:0]       q_status, p_status;
    logic signed [15:0] p_kp, p_ki;

    logic [NSTAGE-1:0]  vld_reg;
    logic               en, push;
    logic               out_vld_reg, skid_vld_reg;
    logic signed [15:0] out_kp_reg, out_ki_reg, skid_kp_reg, skid_ki_reg;
    logic [1:0]         out_st_reg, skid_st_reg;

    assign pready = 1'b1;

    fzpid_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    fzpid_quant u_quant (
        .aclk              (aclk),
        .en                (en),
        .set_point         (s_set_point),
        .measured          (s_measured),
        .previous_measured (s_previous_measured),
        .cfg               (cfg),
        .qe                (qe),
        .qc                (qc),
        .status            (q_status)
    );

    fzpid_blend u_blend (
        .aclk      (aclk),
        .en        (en),
        .qe        (qe),
        .qc        (qc),
        .status_in (q_status),
        .cfg       (cfg),
        .kp_adjust (p_kp),
        .ki_adjust (p_ki),
        .status    (p_status)
    );

    // pipeline moves whenever the skid slot is free
    assign en      = !skid_vld_reg;
    assign s_ready = en;
    assign push    = en && vld_reg[NSTAGE-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTAGE-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (!out_vld_reg || m_ready) begin
            if (skid_vld_reg) begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end else begin
                out_vld_reg <= push;
            end
        end else if (push) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_vld_reg || m_ready) begin
            if (skid_vld_reg) begin
                out_kp_reg <= skid_kp_reg;
                out_ki_reg <= skid_ki_reg;
                out_st_reg <= skid_st_reg;
            end else begin
                out_kp_reg <= p_kp;
                out_ki_reg <= p_ki;
                out_st_reg <= p_status;
            end
        end else if (push) begin
            skid_kp_reg <= p_kp;
            skid_ki_reg <= p_ki;
            skid_st_reg <= p_status;
        end
    end

    assign m_valid     = out_vld_reg;
    assign m_kp_adjust = out_kp_reg;
    assign m_ki_adjust = out_ki_reg;
    assign m_status    = out_st_reg;

endmodule

`default_nettype wire

[tb/sv/fuzzy_pid_gain_adjust_core_test.sv]
// testbench for fuzzy_pid_gain_adjust_core: drives random and directed samples,
// predicts each gain adjustment word and checks it; depends on fzpid_pkg and the core
`default_nettype none

module fuzzy_pid_gain_adjust_core_test;

    typedef struct packed {
        logic signed [15:0] sp;
        logic signed [15:0] ms;
        logic signed [15:0] pv;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] kp;
        logic signed [15:0] ki;
        logic [1:0]         st;
    } gains_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_set_point = '0, s_measured = '0, s_previous_measured = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [15:0] m_kp_adjust, m_ki_adjust;
    logic [1:0] m_status;

    fuzzy_pid_gain_adjust_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_set_point(s_set_point),
        .s_measured(s_measured), .s_previous_measured(s_previous_measured),
        .m_valid(m_valid), .m_ready(m_ready), .m_kp_adjust(m_kp_adjust),
        .m_ki_adjust(m_ki_adjust), .m_status(m_status)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // predictor copy of the registers
    logic [14:0] lim_lo = fzpid_pkg::LOWER_RST, lim_hi = fzpid_pkg::UPPER_RST;
    logic [15:0] kp_gain = fzpid_pkg::KP_RST, ki_gain = fzpid_pkg::KI_RST;

    sample_t samples_pending[$];
    gains_t  gains_expected[$];
    int unsigned send_idle_pct = 0, recv_idle_pct = 0;
    int unsigned hold_cycles = 0;
    bit failed = 1'b0;

    function automatic longint floor_div(longint n, longint d);
        if (n >= 0) return n / d;
        return -(((-n) + d - 1) / d);
    endfunction

    function automatic void level_weights(longint q, output int idx,
                                          output longint w_in, output longint w_out);
        longint mag;
        mag = q < 0 ? -q : q;
        w_out = (9372 * mag) >>> 16;
        w_in = 65536 - w_out;
        if (q < -3 * 65536) idx = 0;
        else if (q < -65536) idx = 1;
        else if (q < 0) idx = 2;
        else if (q < 65536) idx = 3;
        else if (q < 3 * 65536) idx = 4;
        else idx = 5;
    endfunction

    function automatic longint mix_rules(bit use_ki, int ie, int ic, longint e0,
                                         longint e1, longint c0, longint c1);
        longint r00, r01, r10, r11;
        r00 = use_ki ? fzpid_pkg::KI_RULES[ie][ic] : fzpid_pkg::KP_RULES[ie][ic];
        r01 = use_ki ? fzpid_pkg::KI_RULES[ie][ic+1] : fzpid_pkg::KP_RULES[ie][ic+1];
        r10 = use_ki ? fzpid_pkg::KI_RULES[ie+1][ic] : fzpid_pkg::KP_RULES[ie+1][ic];
        r11 = use_ki ? fzpid_pkg::KI_RULES[ie+1][ic+1] : fzpid_pkg::KP_RULES[ie+1][ic+1];
        return e0 * (c0 * r00 + c1 * r01) + e1 * (c0 * r10 + c1 * r11);
    endfunction

    function automatic logic signed [15:0] round_sat(longint sum, longint gain);
        longint v;
        v = (sum * gain + (64'sd1 <<< 33)) >>> 34;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic gains_t predict_gains(sample_t x);
        gains_t g;
        longint s, err, derr, qe, qc, e0, e1, c0, c1;
        int ie, ic;
        g = '0;
        s = longint'(lim_lo) + longint'(lim_hi);
        if (s == 0) begin
            g.st = fzpid_pkg::ST_ZERO;
            return g;
        end
        err = longint'(x.sp) - longint'(x.ms);
        derr = longint'(x.pv) - longint'(x.ms);
        qe = floor_div(7 * err * 65536, s);
        qc = floor_div(7 * derr * 65536, 2 * s);
        if (qe < -7 * 65536 || qe >= 7 * 65536 || qc < -7 * 65536 || qc >= 7 * 65536) begin
            g.st = fzpid_pkg::ST_RANGE;
            return g;
        end
        level_weights(qe, ie, e0, e1);
        level_weights(qc, ic, c0, c1);
        g.kp = round_sat(mix_rules(1'b0, ie, ic, e0, e1, c0, c1), kp_gain);
        g.ki = round_sat(mix_rules(1'b1, ie, ic, e0, e1, c0, c1), ki_gain);
        g.st = fzpid_pkg::ST_OK;
        return g;
    endfunction

    // driver: keeps valid and payload stable until accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (samples_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                sample_t x;
                x = samples_pending.pop_front();
                gains_expected.push_back(predict_gains(x));
                s_set_point <= x.sp;
                s_measured <= x.ms;
                s_previous_measured <= x.pv;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver backpressure, with an optional long hold-off
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (gains_expected.size() == 0) begin
                $display("%0t: unexpected word kp=%0d ki=%0d st=%0d", $time,
                         m_kp_adjust, m_ki_adjust, m_status);
                failed = 1'b1;
            end else begin
                gains_t g;
                g = gains_expected.pop_front();
                if (m_kp_adjust !== g.kp) begin
                    $display("%0t: kp_adjust expected %0d actual %0d", $time, g.kp, m_kp_adjust);
                    failed = 1'b1;
                end
                if (m_ki_adjust !== g.ki) begin
                    $display("%0t: ki_adjust expected %0d actual %0d", $time, g.ki, m_ki_adjust);
                    failed = 1'b1;
                end
                if (m_status !== g.st) begin
                    $display("%0t: status expected %0d actual %0d", $time, g.st, m_status);
                    failed = 1'b1;
                end
            end
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            fzpid_pkg::REG_LOWER: lim_lo = val[14:0];
            fzpid_pkg::REG_UPPER: lim_hi = val[14:0];
            fzpid_pkg::REG_KP:    kp_gain = val[15:0];
            default:              ki_gain = val[15:0];
        endcase
    endtask

    task automatic drain();
        while (samples_pending.size() > 0 || s_valid || gains_expected.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic push_sample(logic [15:0] sp, logic [15:0] ms, logic [15:0] pv);
        sample_t x;
        x.sp = sp; x.ms = ms; x.pv = pv;
        samples_pending.push_back(x);
    endtask

    // mostly in-range error: small spread around the measurement
    task automatic push_random(int unsigned n);
        int unsigned spread;
        logic [15:0] ms;
        repeat (n) begin
            ms = 16'($urandom);
            if ($urandom_range(9) < 2) begin
                push_sample(16'($urandom), ms, 16'($urandom));
            end else begin
                spread = int'(lim_lo) + int'(lim_hi) + 1;
                push_sample(ms + 16'(int'($urandom_range(2 * spread)) - int'(spread)), ms,
                            ms + 16'(int'($urandom_range(4 * spread)) - 2 * int'(spread)));
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, zero error, segment bounds, out of range
        push_sample(16'h0000, 16'h0000, 16'h0000);
        push_sample(16'h7fff, 16'h8000, 16'h8000);
        push_sample(16'h8000, 16'h7fff, 16'hffff);
        push_sample(16'h7fff, 16'h7fff, 16'h8000);
        push_sample(16'hffff, 16'h0000, 16'h7fff);
        push_sample(16'd15359, 16'd0, 16'd0);
        push_sample(-16'sd15360, 16'd0, 16'd0);
        push_sample(16'd15360, 16'd0, 16'd0);
        push_sample(16'd0, 16'd0, 16'd30719);
        push_sample(16'd0, 16'd0, -16'sd30720);
        push_sample(16'd6583, 16'd0, 16'd6583);
        push_sample(16'd2195, 16'd0, -16'sd2195);
        push_sample(-16'sd6583, 16'd100, 16'd13166);
        push_sample(16'd1, 16'd0, 16'hffff);
        drain();

        send_idle_pct = 26; recv_idle_pct = 75;
        push_random(450);
        drain();

        // extremes: big scales saturate, tiny limits push most samples out of range
        reg_write(fzpid_pkg::REG_KP, 32'hffff);
        reg_write(fzpid_pkg::REG_KI, 32'hffff);
        reg_write(fzpid_pkg::REG_LOWER, 32'd1);
        reg_write(fzpid_pkg::REG_UPPER, 32'd0);
        send_idle_pct = 75; recv_idle_pct = 26;
        push_sample(16'd0, 16'd0, 16'd0);
        push_sample(16'hffff, 16'd0, 16'hffff);
        push_random(200);
        drain();

        reg_write(fzpid_pkg::REG_LOWER, 32'h7fff);
        reg_write(fzpid_pkg::REG_UPPER, 32'h7fff);
        push_random(200);
        drain();

        reg_write(fzpid_pkg::REG_LOWER, 32'd0);
        reg_write(fzpid_pkg::REG_UPPER, 32'd0);
        push_sample(16'd5, 16'd0, 16'd0);
        push_sample(16'h8000, 16'h7fff, 16'd0);
        drain();

        reg_write(fzpid_pkg::REG_LOWER, 32'd0);
        reg_write(fzpid_pkg::REG_UPPER, 32'd3000);
        reg_write(fzpid_pkg::REG_KP, 32'd0);
        reg_write(fzpid_pkg::REG_KI, 32'd40000);
        send_idle_pct = 0; recv_idle_pct = 0;
        push_random(300);
        // long stall on the result side while words keep coming
        hold_cycles = 300;
        drain();

        reg_write(fzpid_pkg::REG_LOWER, 32'd7680);
        reg_write(fzpid_pkg::REG_UPPER, 32'd7680);
        reg_write(fzpid_pkg::REG_KP, 32'd18350);
        reg_write(fzpid_pkg::REG_KI, 32'd6554);
        push_random(350);
        drain();

        if (!failed) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
